/* hw/rtl/rsel_pkg.sv */
// Shared types and constants for the ranked index selector.
package rsel_pkg;

  localparam int KEY_FIELD_W = 32;
  localparam int IDX_W       = 6;
  localparam int CNT_FIELD_W = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 2'd1;

  localparam logic [CNT_FIELD_W-1:0] OUT_COUNT_RESET = 7'd1;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } ent_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
    logic dir;
  } cell_ctl_t;

endpackage

/* hw/rtl/rsel_cell.sv */
// One slot of the sorted chain: insert with shift right, drain with shift left.
module rsel_cell #(
  parameter int KEY_W = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rsel_pkg::cell_ctl_t       ctl,
  input  logic signed [KEY_W-1:0]   new_key,
  input  logic [rsel_pkg::IDX_W-1:0] new_idx,
  input  logic signed [KEY_W-1:0]   prev_key,
  input  rsel_pkg::ent_t            prev_ent,
  input  logic                      prev_beats,
  input  logic signed [KEY_W-1:0]   next_key,
  input  rsel_pkg::ent_t            next_ent,
  output logic signed [KEY_W-1:0]   own_key,
  output rsel_pkg::ent_t            own_ent,
  output logic                      beats
);

  logic signed [KEY_W-1:0] key_r, key_nxt;
  rsel_pkg::ent_t          ent_r, ent_nxt;

  always_comb begin
    if (!ent_r.vld) begin
      beats = 1'b1;
    end else if (ctl.dir) begin
      beats = new_key > key_r;
    end else begin
      beats = new_key < key_r;
    end
  end

  always_comb begin
    key_nxt = key_r;
    ent_nxt = ent_r;
    priority if (ctl.clr) begin
      ent_nxt.vld = 1'b0;
    end else if (ctl.shift) begin
      key_nxt = next_key;
      ent_nxt = next_ent;
    end else if (ctl.ins && beats) begin
      if (prev_beats) begin
        key_nxt = prev_key;
        ent_nxt = prev_ent;
      end else begin
        key_nxt = new_key;
        ent_nxt.vld = 1'b1;
        ent_nxt.idx = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    ent_r.idx <= ent_nxt.idx;
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
  end

  assign own_key = key_r;
  assign own_ent = ent_r;

endmodule

/* hw/rtl/ranked_index_select.sv */
// Keys load one per cycle; the first ranked position is valid the cycle after the last key.
// One key per cycle is taken while loading, then one ranked position per cycle while drained and out_tready is high.
// Each insert places the key in a sorted row of MAX_KEYS cells.
// Input is held off while the K positions of a set drain from the head cell.
// Reset (rst_n low, synchronous) empties the row, zeroes the count, sets direction 0, count 1.
module ranked_index_select #(
  parameter int MAX_KEYS  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [rsel_pkg::KEY_FIELD_W-1:0]      in_tdata,   // [31:0] key
  input  logic                                  in_tlast,   // last_in
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rsel_pkg::OUT_DATA_W-1:0]       out_tdata,  // [5:0] rank_index, [7:6] zero
  output logic                                  out_tlast,  // last_out
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rsel_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rsel_pkg::CNT_FIELD_W-1:0]      cfg_data
);

  localparam int STORE_W = (KEY_WIDTH < rsel_pkg::KEY_FIELD_W) ? KEY_WIDTH
                                                                : rsel_pkg::KEY_FIELD_W;
  localparam int CNT_W   = $clog2(MAX_KEYS + 1);

  rsel_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [rsel_pkg::CNT_FIELD_W-1:0] remain_r, remain_nxt;
  logic                             dir_r;
  logic [rsel_pkg::CNT_FIELD_W-1:0] out_count_r;

  rsel_pkg::cell_ctl_t ctl;
  logic in_acc, out_acc, full;
  logic [rsel_pkg::CNT_FIELD_W-1:0] cnt_after, k_val;

  logic signed [STORE_W-1:0] new_key;
  logic signed [STORE_W-1:0] cell_key   [MAX_KEYS];
  rsel_pkg::ent_t            cell_ent   [MAX_KEYS];
  logic                      cell_beats [MAX_KEYS];

  assign new_key   = in_tdata[STORE_W-1:0];
  assign in_tready = (state_r == rsel_pkg::ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == rsel_pkg::ST_EMIT);
  assign out_acc   = out_tvalid && out_tready;
  assign out_tdata = rsel_pkg::OUT_DATA_W'(cell_ent[0].idx);
  assign out_tlast = (remain_r == rsel_pkg::CNT_FIELD_W'(1));
  assign cfg_ready = 1'b1;

  assign full      = (count_r == CNT_W'(MAX_KEYS));
  assign cnt_after = full ? rsel_pkg::CNT_FIELD_W'(count_r)
                          : rsel_pkg::CNT_FIELD_W'(count_r) + rsel_pkg::CNT_FIELD_W'(1);
  assign k_val     = (out_count_r < cnt_after) ? out_count_r : cnt_after;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    remain_nxt = remain_r;
    ctl.ins    = 1'b0;
    ctl.shift  = 1'b0;
    ctl.clr    = 1'b0;
    ctl.dir    = dir_r;
    unique case (state_r)
      rsel_pkg::ST_LOAD: begin
        if (in_acc) begin
          ctl.ins = !full;
          if (!full) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_tlast) begin
            if (k_val == '0) begin
              ctl.clr   = 1'b1;
              count_nxt = '0;
            end else begin
              remain_nxt = k_val;
              state_nxt  = rsel_pkg::ST_EMIT;
            end
          end
        end
      end
      rsel_pkg::ST_EMIT: begin
        if (out_acc) begin
          ctl.shift  = 1'b1;
          remain_nxt = remain_r - rsel_pkg::CNT_FIELD_W'(1);
          if (out_tlast) begin
            ctl.clr   = 1'b1;
            count_nxt = '0;
            state_nxt = rsel_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = rsel_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    if (!rst_n) begin
      state_r     <= rsel_pkg::ST_LOAD;
      count_r     <= '0;
      dir_r       <= 1'b0;
      out_count_r <= rsel_pkg::OUT_COUNT_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rsel_pkg::REG_DIRECTION: dir_r       <= cfg_data[0];
          rsel_pkg::REG_OUT_COUNT: out_count_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    logic signed [STORE_W-1:0] prev_key, next_key;
    rsel_pkg::ent_t            prev_ent, next_ent;
    logic                      prev_beats;

    if (i == 0) begin : g_head
      assign prev_key   = '0;
      assign prev_ent   = '0;
      assign prev_beats = 1'b0;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_ent   = cell_ent[i-1];
      assign prev_beats = cell_beats[i-1];
    end

    if (i == MAX_KEYS - 1) begin : g_tail
      assign next_key = '0;
      assign next_ent = '0;
    end else begin : g_inner
      assign next_key = cell_key[i+1];
      assign next_ent = cell_ent[i+1];
    end

    rsel_cell #(
      .KEY_W (STORE_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_key    (new_key),
      .new_idx    (rsel_pkg::IDX_W'(count_r)),
      .prev_key   (prev_key),
      .prev_ent   (prev_ent),
      .prev_beats (prev_beats),
      .next_key   (next_key),
      .next_ent   (next_ent),
      .own_key    (cell_key[i]),
      .own_ent    (cell_ent[i]),
      .beats      (cell_beats[i])
    );
  end

endmodule
